>>> sv/fm_synth_voice_top_macros.svh
// ----------------------------------------------------------------------------
// fm_synth_voice_top_macros.svh
// Assertion macros shared by the checker of the FM synthesis voice.
// ----------------------------------------------------------------------------
`ifndef FM_SYNTH_VOICE_TOP_MACROS_SVH
`define FM_SYNTH_VOICE_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet during reset.
`define FSV_ASSERT_NOW(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
    else $error("fsv assertion failed");

// Next-cycle implication, clocked on clk and quiet during reset.
`define FSV_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("fsv assertion failed");

`endif

>>> sv/fsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_pkg
// Types, register indexes and the sine table of the FM synthesis voice.
// ----------------------------------------------------------------------------
package fsv_pkg;

  localparam int SINE_ENTRIES = 256;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int STATE_WORDS  = 5;

  localparam logic [15:0] ENV_FULL = 16'd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_INC = 3'd0,
    REG_FALL_SHIFT  = 3'd1,
    REG_RISE_SHIFT  = 3'd2,
    REG_MOD_INC     = 3'd3,
    REG_DEPTH_SHIFT = 3'd4,
    REG_MOD_DECAY   = 3'd5
  } cfg_reg_t;

  // Word addresses of the voice state memory.
  typedef enum logic [2:0] {
    A_FALL = 3'd0,
    A_RISE = 3'd1,
    A_MOD  = 3'd2,
    A_MPH  = 3'd3,
    A_CPH  = 3'd4
  } st_addr_t;

  typedef logic signed [7:0] sine_t;

  localparam sine_t SINE_TAB [SINE_ENTRIES] = '{
    8'sd0, 8'sd3, 8'sd6, 8'sd9, 8'sd12, 8'sd15, 8'sd18, 8'sd21,
    8'sd24, 8'sd27, 8'sd30, 8'sd33, 8'sd36, 8'sd39, 8'sd42, 8'sd45,
    8'sd48, 8'sd51, 8'sd54, 8'sd57, 8'sd59, 8'sd62, 8'sd65, 8'sd67,
    8'sd70, 8'sd73, 8'sd75, 8'sd78, 8'sd80, 8'sd82, 8'sd85, 8'sd87,
    8'sd89, 8'sd91, 8'sd94, 8'sd96, 8'sd98, 8'sd100, 8'sd102, 8'sd103,
    8'sd105, 8'sd107, 8'sd108, 8'sd110, 8'sd112, 8'sd113, 8'sd114, 8'sd116,
    8'sd117, 8'sd118, 8'sd119, 8'sd120, 8'sd121, 8'sd122, 8'sd123, 8'sd123,
    8'sd124, 8'sd125, 8'sd125, 8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd126,
    8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd125, 8'sd125,
    8'sd124, 8'sd123, 8'sd123, 8'sd122, 8'sd121, 8'sd120, 8'sd119, 8'sd118,
    8'sd117, 8'sd116, 8'sd114, 8'sd113, 8'sd112, 8'sd110, 8'sd108, 8'sd107,
    8'sd105, 8'sd103, 8'sd102, 8'sd100, 8'sd98, 8'sd96, 8'sd94, 8'sd91,
    8'sd89, 8'sd87, 8'sd85, 8'sd82, 8'sd80, 8'sd78, 8'sd75, 8'sd73,
    8'sd70, 8'sd67, 8'sd65, 8'sd62, 8'sd59, 8'sd57, 8'sd54, 8'sd51,
    8'sd48, 8'sd45, 8'sd42, 8'sd39, 8'sd36, 8'sd33, 8'sd30, 8'sd27,
    8'sd24, 8'sd21, 8'sd18, 8'sd15, 8'sd12, 8'sd9, 8'sd6, 8'sd3,
    8'sd0, -8'sd3, -8'sd6, -8'sd9, -8'sd12, -8'sd15, -8'sd18, -8'sd21,
    -8'sd24, -8'sd27, -8'sd30, -8'sd33, -8'sd36, -8'sd39, -8'sd42, -8'sd45,
    -8'sd48, -8'sd51, -8'sd54, -8'sd57, -8'sd59, -8'sd62, -8'sd65, -8'sd67,
    -8'sd70, -8'sd73, -8'sd75, -8'sd78, -8'sd80, -8'sd82, -8'sd85, -8'sd87,
    -8'sd89, -8'sd91, -8'sd94, -8'sd96, -8'sd98, -8'sd100, -8'sd101, -8'sd103,
    -8'sd105, -8'sd107, -8'sd108, -8'sd110, -8'sd111, -8'sd113, -8'sd114, -8'sd116,
    -8'sd117, -8'sd118, -8'sd119, -8'sd120, -8'sd121, -8'sd122, -8'sd123, -8'sd123,
    -8'sd124, -8'sd125, -8'sd125, -8'sd126, -8'sd126, -8'sd126, -8'sd126, -8'sd126,
    -8'sd126, -8'sd126, -8'sd126, -8'sd126, -8'sd126, -8'sd126, -8'sd125, -8'sd125,
    -8'sd124, -8'sd123, -8'sd123, -8'sd122, -8'sd121, -8'sd120, -8'sd119, -8'sd118,
    -8'sd117, -8'sd116, -8'sd114, -8'sd113, -8'sd112, -8'sd110, -8'sd108, -8'sd107,
    -8'sd105, -8'sd103, -8'sd102, -8'sd100, -8'sd98, -8'sd96, -8'sd94, -8'sd91,
    -8'sd89, -8'sd87, -8'sd85, -8'sd82, -8'sd80, -8'sd78, -8'sd75, -8'sd73,
    -8'sd70, -8'sd67, -8'sd65, -8'sd62, -8'sd59, -8'sd57, -8'sd54, -8'sd51,
    -8'sd48, -8'sd45, -8'sd42, -8'sd39, -8'sd36, -8'sd33, -8'sd30, -8'sd27,
    -8'sd24, -8'sd21, -8'sd18, -8'sd15, -8'sd12, -8'sd9, -8'sd6, -8'sd3
  };

  function automatic sine_t sine_lookup(input logic [7:0] idx);
    return SINE_TAB[idx];
  endfunction

endpackage

>>> sv/fm_synth_voice_top.sv
`timescale 1ns / 1ps
// An item's sample is registered onto out_valid in the output state, after the fall, rise,
// mod, mph and cph states; a new item is taken only in idle. The five state words are read
// and written back one per cycle through the single port pair of the voice state memory.
// Reset (rst_n low, synchronous): phases and envelopes read as zero, the tick count is
// zero, configuration registers return to their defaults, no sample is pending.
// ----------------------------------------------------------------------------
// fm_synth_voice_top
// One voice of a two-operator FM synthesizer: one 8-bit sample per tick item.
// ----------------------------------------------------------------------------
module fm_synth_voice_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_pluck,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_pcm_sample,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsv_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fsv_pkg::*;

  // The sequencer walks the state words in a fixed order. Each state sees the read
  // data of the word addressed in the state before it, modifies it and writes it back.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FALL,
    S_RISE,
    S_MOD,
    S_MPH,
    S_CPH,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [15:0] car_inc_r;
  logic [15:0] mod_inc_r;
  logic [3:0]  fall_shift_r;
  logic [3:0]  rise_shift_r;
  logic [3:0]  depth_shift_r;
  logic [3:0]  mod_decay_r;

  // Per-item working registers.
  logic        pluck_r;
  logic        tick_zero_r;
  logic [7:0]  tick_r;
  logic [15:0] fall_dec_r;
  logic [15:0] amp_r;
  logic [15:0] mod_scaled_r;
  logic [15:0] fm_prod_r;
  sine_t       csine_r;
  logic        out_valid_r;
  logic [7:0]  out_sample_r;

  // Voice state memory. It has no reset of its own; a valid bit per word makes a
  // word that has not been written since reset read as zero.
  logic [15:0]            mem [STATE_WORDS];
  logic [STATE_WORDS-1:0] vld_r;
  logic [15:0]            rd_data_r;
  logic                   rd_vld_r;
  st_addr_t               rd_addr;
  logic                   wr_en;
  st_addr_t               wr_addr;
  logic [15:0]            wr_data;

  logic [15:0] rd_word;
  logic [3:0]  dec_shift;
  logic [15:0] decayed;
  logic [15:0] attack;
  logic [15:0] env_new;
  logic [15:0] mod_eff;
  logic [15:0] mph_new;
  logic [15:0] cph_new;
  logic [15:0] phase_base;
  sine_t       msine;

  // One multiplier serves the amplitude, the FM term and the output scaling, each in
  // a different state of the sequence.
  logic signed [8:0]  mul_a;
  logic signed [16:0] mul_b;
  logic signed [25:0] mul_p;
  logic [7:0]         sample_nxt;

  logic in_accept;
  logic out_accept;

  assign in_stall       = (state_r != S_IDLE);
  assign in_accept      = in_valid && !in_stall;
  assign out_accept     = out_valid_r && !out_stall;
  assign out_valid      = out_valid_r;
  assign out_pcm_sample = out_sample_r;
  assign cfg_ready      = 1'b1;

  // Read address for the word that the next state works on.
  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = A_FALL;
      S_FALL:  rd_addr = A_RISE;
      S_RISE:  rd_addr = A_MOD;
      S_MOD:   rd_addr = A_MPH;
      default: rd_addr = A_CPH;
    endcase
  end

  assign rd_word = rd_vld_r ? rd_data_r : 16'd0;

  always_comb begin
    case (state_r)
      S_FALL:  dec_shift = fall_shift_r;
      S_RISE:  dec_shift = rise_shift_r;
      default: dec_shift = mod_decay_r;
    endcase
  end

  // Envelopes decay only on the tick whose count, sampled before the increment, is zero.
  assign decayed    = tick_zero_r ? (rd_word - (rd_word >> dec_shift)) : rd_word;
  assign attack     = ENV_FULL - decayed;
  assign env_new    = pluck_r ? ENV_FULL : decayed;
  assign mod_eff    = env_new;
  assign phase_base = pluck_r ? 16'd0 : rd_word;
  assign mph_new    = phase_base + mod_inc_r;
  assign cph_new    = phase_base + car_inc_r + fm_prod_r;
  assign msine      = sine_lookup(mph_new[15:8]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = A_FALL;
    wr_data = env_new;
    case (state_r)
      S_FALL: begin
        wr_en   = 1'b1;
        wr_addr = A_FALL;
      end
      S_RISE: begin
        wr_en   = 1'b1;
        wr_addr = A_RISE;
      end
      S_MOD: begin
        wr_en   = 1'b1;
        wr_addr = A_MOD;
      end
      S_MPH: begin
        wr_en   = 1'b1;
        wr_addr = A_MPH;
        wr_data = mph_new;
      end
      S_CPH: begin
        wr_en   = 1'b1;
        wr_addr = A_CPH;
        wr_data = cph_new;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Operand selection for the shared multiplier. The amplitude uses the envelopes
  // before any pluck: the decayed fall value and the decayed rise remainder.
  always_comb begin
    case (state_r)
      S_RISE: begin
        mul_a = {1'b0, attack[15:8]};
        mul_b = {9'd0, fall_dec_r[15:8]};
      end
      S_MPH: begin
        mul_a = {msine[7], msine};
        mul_b = {1'b0, mod_scaled_r};
      end
      default: begin
        mul_a = {csine_r[7], csine_r};
        mul_b = {9'd0, amp_r[15:8]};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Arithmetic shift right by seven, then the offset to center on 128, modulo 256.
  assign sample_nxt = 8'd128 + mul_p[14:7];

  // State memory: one write and one registered read per cycle. Each word is written once
  // per item and the next item starts only after the last write. The carrier phase word is
  // also read while it is written, but that read data is not used.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Sequencer, configuration registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tick_r        <= 8'd0;
      out_valid_r   <= 1'b0;
      car_inc_r     <= 16'd11796;
      fall_shift_r  <= 4'd5;
      rise_shift_r  <= 4'd1;
      mod_inc_r     <= 16'd4915;
      depth_shift_r <= 4'd8;
      mod_decay_r   <= 4'd6;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CARRIER_INC: car_inc_r     <= cfg_data;
          REG_FALL_SHIFT:  fall_shift_r  <= cfg_data[3:0];
          REG_RISE_SHIFT:  rise_shift_r  <= cfg_data[3:0];
          REG_MOD_INC:     mod_inc_r     <= cfg_data;
          REG_DEPTH_SHIFT: depth_shift_r <= cfg_data[3:0];
          REG_MOD_DECAY:   mod_decay_r   <= cfg_data[3:0];
          default: begin
          end
        endcase
      end

      // In the output state the sequencer below decides the valid flag itself.
      if (out_accept && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            pluck_r     <= in_pluck;
            tick_zero_r <= (tick_r == 8'd0);
            tick_r      <= tick_r + 8'd1;
            state_r     <= S_FALL;
          end
        end
        S_FALL: begin
          fall_dec_r <= decayed;
          state_r    <= S_RISE;
        end
        S_RISE: begin
          amp_r   <= mul_p[15:0];
          state_r <= S_MOD;
        end
        S_MOD: begin
          mod_scaled_r <= mod_eff >> depth_shift_r;
          state_r      <= S_MPH;
        end
        S_MPH: begin
          fm_prod_r <= mul_p[15:0];
          state_r   <= S_CPH;
        end
        S_CPH: begin
          csine_r <= sine_lookup(cph_new[15:8]);
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Hold here while an earlier sample still waits on a stalled output.
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= sample_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/fsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_checker
// Port-level checks of the FM synthesis voice, bound to the top level.
// ----------------------------------------------------------------------------
`include "fm_synth_voice_top_macros.svh"

module fsv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pcm_sample
);

  // A stalled sample stays offered and unchanged.
  `FSV_ASSERT_NEXT(a_out_hold_valid, out_valid && out_stall, out_valid)
  `FSV_ASSERT_NEXT(a_out_hold_data, out_valid && out_stall, $stable(out_pcm_sample))
  // The voice works on one item at a time, so it is busy right after an accept.
  `FSV_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A new sample appears as the sequence finishes, which frees the input side.
  `FSV_ASSERT_NOW(a_free_on_result, $rose(out_valid), !in_stall)

endmodule

bind fm_synth_voice_top fsv_checker u_fsv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pcm_sample (out_pcm_sample)
);
